### rtl/core/sha1_hash_engine_assert.svh
// Assertion macros for the checker file of the hash engine.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// General property, sampled on the rising clock edge and idle during reset.
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A stalled item keeps its valid and its payload in the next cycle.
`define SHA1_ASSERT_HOLD(lbl, vld, stl, pay, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && (stl)) |=> ((vld) && $stable(pay))) else $error(msg);

`endif

### rtl/core/sha1_pkg.sv
package sha1_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;
  } out_item_t;

  localparam int unsigned NumChain = 5;
  localparam int unsigned RingDepth = 16;

  localparam logic [NumChain-1:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [2:0]  LastIndex = 3'd4;
  localparam logic [6:0]  LastRound = 7'd79;

endpackage

### rtl/core/sha1_hash_engine.sv
// SHA-1 hash engine.
// The input channel takes the message as big-endian 32-bit words, each item
// with a count of valid leading bytes and a flag that marks the last word.
// The output channel gives the five digest words H0 to H4 as five items,
// the fifth one flagged as last.
// A word that does not complete a block leaves the engine ready for the next
// word. The sixteenth word of a block starts the compression: 80 rounds, one
// per cycle through a single shared round adder, then a step that folds the
// result into the chain. After the last word the engine pushes the padding
// and length words, one per cycle, runs one or two compressions and then
// shows the digest words. While the engine works or shows the digest,
// in_stall_o is high. A stalled digest item holds its value until it is
// taken. When the fifth item is taken the engine returns to its initial
// state. Reset clears the chaining words to the SHA-1 initial values, the
// length and the sequencer; the engine is then ready for a new message.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [3:0]  wib_q, wib_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [63:0] len_q, len_d;
  logic        pad80_q, pad80_d;
  logic        lenhi_q, lenhi_d;
  logic        done_q, done_d;
  logic        fin_q, fin_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] chain_q [NumChain];
  logic [31:0] chain_d [NumChain];
  logic [31:0] wrk_q [NumChain];
  logic [31:0] wrk_d [NumChain];
  logic [31:0] sched_q [RingDepth];
  logic [31:0] sched_d [RingDepth];

  logic        in_acc, out_acc;
  logic        push_en;
  logic [31:0] push_word;
  logic [2:0]  nb;
  logic [31:0] f_val, k_val, w_mix, w_t, sum;

  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    out_item_o.word_index  = idx_q;
    out_item_o.last_digest = (idx_q == LastIndex);
    case (idx_q)
      3'd0:    out_item_o.digest_word = chain_q[0];
      3'd1:    out_item_o.digest_word = chain_q[1];
      3'd2:    out_item_o.digest_word = chain_q[2];
      3'd3:    out_item_o.digest_word = chain_q[3];
      default: out_item_o.digest_word = chain_q[4];
    endcase
  end

  assign nb = (in_item_i.valid_bytes > 3'd4) ? 3'd4 : in_item_i.valid_bytes;

  // Round function and constant for the current round.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (wrk_q[1] & wrk_q[2]) | (~wrk_q[1] & wrk_q[3]);
      k_val = K0;
    end else if (rnd_q < 7'd40) begin
      f_val = wrk_q[1] ^ wrk_q[2] ^ wrk_q[3];
      k_val = K1;
    end else if (rnd_q < 7'd60) begin
      f_val = (wrk_q[1] & wrk_q[2]) | (wrk_q[1] & wrk_q[3]) | (wrk_q[2] & wrk_q[3]);
      k_val = K2;
    end else begin
      f_val = wrk_q[1] ^ wrk_q[2] ^ wrk_q[3];
      k_val = K3;
    end
  end

  // The schedule window holds the last sixteen words, oldest at index 0.
  assign w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign w_t   = (rnd_q < 7'd16) ? sched_q[0] : {w_mix[30:0], w_mix[31]};
  assign sum   = {wrk_q[0][26:0], wrk_q[0][31:27]} + f_val + wrk_q[4] + w_t + k_val;

  always_comb begin
    state_d   = state_q;
    wib_d     = wib_q;
    rnd_d     = rnd_q;
    len_d     = len_q;
    pad80_d   = pad80_q;
    lenhi_d   = lenhi_q;
    done_d    = done_q;
    fin_d     = fin_q;
    idx_d     = idx_q;
    chain_d   = chain_q;
    wrk_d     = wrk_q;
    sched_d   = sched_q;
    push_en   = 1'b0;
    push_word = '0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          push_en = 1'b1;
          if (!in_item_i.last_word) begin
            push_word = in_item_i.message_word;
            len_d     = len_q + 64'd32;
          end else begin
            fin_d   = 1'b1;
            pad80_d = (nb == 3'd4);
            len_d   = len_q + {58'd0, nb, 3'd0};
            case (nb)
              3'd0:    push_word = PadWord;
              3'd1:    push_word = {in_item_i.message_word[31:24], 24'h800000};
              3'd2:    push_word = {in_item_i.message_word[31:16], 16'h8000};
              3'd3:    push_word = {in_item_i.message_word[31:8], 8'h80};
              default: push_word = in_item_i.message_word;
            endcase
            state_d = StPad;
          end
        end
      end
      StPad: begin
        push_en = 1'b1;
        if (pad80_q) begin
          push_word = PadWord;
          pad80_d   = 1'b0;
        end else if (lenhi_q) begin
          push_word = len_q[31:0];
          done_d    = 1'b1;
        end else if (wib_q == 4'd14) begin
          push_word = len_q[63:32];
          lenhi_d   = 1'b1;
        end else begin
          push_word = '0;
        end
      end
      StRound: begin
        for (int i = 0; i < RingDepth - 1; i++) begin
          sched_d[i] = sched_q[i+1];
        end
        sched_d[RingDepth-1] = w_t;
        wrk_d[0] = sum;
        wrk_d[1] = wrk_q[0];
        wrk_d[2] = {wrk_q[1][1:0], wrk_q[1][31:2]};
        wrk_d[3] = wrk_q[2];
        wrk_d[4] = wrk_q[3];
        if (rnd_q == LastRound) begin
          state_d = StFinal;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      StFinal: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + wrk_q[i];
        end
        if (done_q) begin
          state_d = StOut;
          idx_d   = '0;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (idx_q == LastIndex) begin
            state_d = StIdle;
            idx_d   = '0;
            wib_d   = '0;
            rnd_d   = '0;
            len_d   = '0;
            pad80_d = 1'b0;
            lenhi_d = 1'b0;
            done_d  = 1'b0;
            fin_d   = 1'b0;
            for (int i = 0; i < NumChain; i++) begin
              chain_d[i] = HInit[i];
              wrk_d[i]   = '0;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (push_en) begin
      for (int i = 0; i < RingDepth - 1; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[RingDepth-1] = push_word;
      wib_d = wib_q + 4'd1;
      if (wib_q == 4'd15) begin
        state_d = StRound;
        rnd_d   = '0;
        wrk_d   = chain_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wib_q   <= '0;
      rnd_q   <= '0;
      len_q   <= '0;
      pad80_q <= 1'b0;
      lenhi_q <= 1'b0;
      done_q  <= 1'b0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < NumChain; i++) begin
        chain_q[i] <= HInit[i];
        wrk_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      wib_q   <= wib_d;
      rnd_q   <= rnd_d;
      len_q   <= len_d;
      pad80_q <= pad80_d;
      lenhi_q <= lenhi_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
      chain_q <= chain_d;
      wrk_q   <= wrk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
  end

endmodule

### rtl/core/sha1_check.sv
`include "sha1_hash_engine_assert.svh"

module sha1_check
  import sha1_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `SHA1_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_item_o, "Stalled digest item changed.")

  `SHA1_ASSERT(a_last_flag, out_valid_o |-> ((out_item_o.word_index <= 3'd4) && (out_item_o.last_digest == (out_item_o.word_index == 3'd4))), "Digest index or last flag is wrong.")

  `SHA1_ASSERT(a_index_step, (out_valid_o && !out_stall_i && !out_item_o.last_digest) |=> (out_valid_o && (out_item_o.word_index == ($past(out_item_o.word_index) + 3'd1))), "Digest words are not in order.")

  `SHA1_ASSERT(a_busy_out, out_valid_o |-> in_stall_o, "Input taken while the digest is shown.")

  `SHA1_ASSERT(a_out_end, (out_valid_o && !out_stall_i && out_item_o.last_digest) |=> (!out_valid_o && !in_stall_o), "Engine did not return to idle after the digest.")

endmodule

bind sha1_hash_engine sha1_check u_sha1_check (.*);

### tb/sv/sha1_hash_engine_tb.sv
`timescale 1ns / 100ps

module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned RandomItems = 285;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallRuns
  } stall_mode_e;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  sha1_hash_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // Words still to be offered to the engine and digest words still owed by it.
  in_item_t    pending_q[$];
  out_item_t   digest_q[$];

  // Running SHA-1 state of the prediction.
  logic [31:0] chain_h[NumChain];
  logic [31:0] sched_w[RingDepth];
  logic [3:0]  blk_pos;
  logic [63:0] msg_bits;

  int unsigned error_count = 0;
  int unsigned words_taken = 0;
  int unsigned messages_taken = 0;
  int unsigned digests_checked = 0;
  int unsigned random_words = 0;
  int unsigned idle_cycles = 0;
  logic        timed_out = 1'b0;
  logic        in_taken = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_timer = 0;
  int unsigned stall_run = 0;

  function automatic void sha1_restart();
    int j;
    for (j = 0; j < NumChain; j++) chain_h[j] = HInit[j];
    for (j = 0; j < RingDepth; j++) sched_w[j] = '0;
    blk_pos = '0;
    msg_bits = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] a, b, c, d, e, f, k, w, sum;
    int t;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      if (t >= 16) begin
        w = sched_w[(t - 3) % 16] ^ sched_w[(t - 8) % 16] ^
            sched_w[(t - 14) % 16] ^ sched_w[t % 16];
        sched_w[t % 16] = {w[30:0], w[31]};
      end
      w = sched_w[t % 16];
      sum = {a[26:0], a[31:27]} + f + e + w + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_absorb(logic [31:0] w);
    sched_w[blk_pos] = w;
    blk_pos = blk_pos + 4'd1;
    if (blk_pos == 4'd0) sha1_compress();
  endfunction

  // Takes one accepted word; a last word finishes the message and queues its digest.
  function automatic void sha1_predict(in_item_t it);
    logic [31:0] word, mask;
    int unsigned nbytes;
    out_item_t   dg;
    int j;
    if (!it.last_word) begin
      msg_bits += 64'd32;
      sha1_absorb(it.message_word);
      return;
    end
    nbytes = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
    mask = (nbytes == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * nbytes));
    word = it.message_word & mask;
    msg_bits += 64'(8 * nbytes);
    if (nbytes < 4) begin
      sha1_absorb(word | (32'h80 << (24 - 8 * nbytes)));
    end else begin
      sha1_absorb(word);
      sha1_absorb(PadWord);
    end
    while (blk_pos != 4'd14) sha1_absorb('0);
    sha1_absorb(msg_bits[63:32]);
    sha1_absorb(msg_bits[31:0]);
    for (j = 0; j < NumChain; j++) begin
      dg.digest_word = chain_h[j];
      dg.word_index = 3'(j);
      dg.last_digest = (3'(j) == LastIndex);
      digest_q.push_back(dg);
    end
    sha1_restart();
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(logic [31:0] w, int unsigned nb, bit last);
    in_item_t it;
    it.message_word = w;
    it.valid_bytes = 3'(nb);
    it.last_word = last;
    pending_q.push_back(it);
  endtask

  task automatic queue_message(int unsigned len);
    int unsigned i;
    for (i = 1; i < len; i++) queue_word(pick_word(), $urandom_range(0, 7), 1'b0);
    if ($urandom_range(0, 5) == 0) queue_word(pick_word(), $urandom_range(5, 7), 1'b1);
    else queue_word(pick_word(), $urandom_range(0, 4), 1'b1);
    random_words += len;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sender: items in bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_item <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: the stall mode is drawn anew each time stall_timer runs out.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 2));
        stall_timer <= 127;
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        StallNone: begin
          out_stall <= 1'b0;
        end
        StallRandom: begin
          out_stall <= $urandom_range(0, 1);
        end
        default: begin
          if (stall_run == 0) begin
            out_stall <= !out_stall;
            stall_run <= out_stall ? $urandom_range(0, 3) : $urandom_range(1, 15);
          end else begin
            stall_run <= stall_run - 1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        words_taken++;
        if (in_item.last_word) messages_taken++;
        sha1_predict(in_item);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        error_count++;
        $display("%0t: digest item %h arrived with none expected", $time, out_item);
      end else begin
        exp_item = digest_q.pop_front();
        digests_checked++;
        if (out_item.digest_word !== exp_item.digest_word) begin
          error_count++;
          $display("%0t: digest_word expected %h, got %h", $time,
                   exp_item.digest_word, out_item.digest_word);
        end
        if (out_item.word_index !== exp_item.word_index) begin
          error_count++;
          $display("%0t: word_index expected %0d, got %0d", $time,
                   exp_item.word_index, out_item.word_index);
        end
        if (out_item.last_digest !== exp_item.last_digest) begin
          error_count++;
          $display("%0t: last_digest expected %b, got %b", $time,
                   exp_item.last_digest, out_item.last_digest);
        end
      end
    end
  end

  // The watchdog only runs while work is outstanding.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_q.size() == 0 && !in_valid && digest_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    sha1_restart();

    // Empty message, the classic three-byte message, and full-word endings.
    queue_word(pick_word(), 0, 1'b1);
    queue_word(32'h61626300, 3, 1'b1);
    queue_word('1, 4, 1'b1);
    // Counts above four on the last word saturate.
    queue_word('1, 5, 1'b1);
    queue_word(pick_word(), 6, 1'b1);
    queue_word('0, 7, 1'b1);
    // The count of a word that is not last is ignored.
    queue_word('1, 0, 1'b0);
    queue_word('0, 4, 1'b1);
    // Fourteen full words leave no room for the length, so an extra block follows.
    for (i = 0; i < 14; i++) queue_word(pick_word(), $urandom_range(0, 7), 1'b0);
    queue_word('1, 1, 1'b1);

    while (random_words < RandomItems) begin
      if ($urandom_range(0, 7) == 0) queue_message($urandom_range(30, 50));
      else queue_message($urandom_range(1, 20));
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_q.size() == 0 && !in_valid) && !timed_out) @(posedge clk_i);
    while (digest_q.size() != 0 && !timed_out) @(posedge clk_i);

    if (timed_out) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("sha1_hash_engine regression: fail");
    end else begin
      repeat (DrainCycles) @(posedge clk_i);
      $display("Hashed %0d messages from %0d words; %0d digest words compared, %0d errors.",
               messages_taken, words_taken, digests_checked, error_count);
      if (error_count == 0) begin
        $display("sha1_hash_engine regression: pass");
      end else begin
        $display("sha1_hash_engine regression: fail");
      end
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sha1_pkg.sv
rtl/core/sha1_hash_engine.sv
rtl/core/sha1_check.sv
tb/sv/sha1_hash_engine_tb.sv
